// ===== hdl/fpha_pkg.sv =====
`timescale 1ns / 1ps

package fpha_pkg;

    localparam int NUM_HOLES_DEF = 8;
    localparam int SIZE_BITS_DEF = 16;

    localparam int CMD_W    = 1;
    localparam int HIDX_W   = 3;
    localparam int AMOUNT_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int POLICY_W   = 2;
    localparam int HOLES_W    = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 1'b0,
        CMD_REQUEST = 1'b1
    } cmd_t;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } policy_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POLICY = 1'b0,
        CFG_HOLES  = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } scan_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [HIDX_W-1:0]   hole_index;
        logic [AMOUNT_W-1:0] amount;
    } req_t;

    typedef struct packed {
        logic                granted;
        logic [HIDX_W-1:0]   chosen_hole;
        logic [AMOUNT_W-1:0] left_in_hole;
    } rsp_t;

endpackage

// ===== hdl/fpha_mem.sv =====
`timescale 1ns / 1ps

module fpha_mem
    import fpha_pkg::*;
#(
    parameter int NUM_HOLES = NUM_HOLES_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    localparam int IDX_W = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [SIZE_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [SIZE_BITS-1:0] wr_data
);

    logic [SIZE_BITS-1:0] mem [NUM_HOLES];
    logic [SIZE_BITS-1:0] rd_data_reg;
    logic [NUM_HOLES-1:0] valid_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // never-written holes read as zero size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hdl/fpha_scan.sv =====
`timescale 1ns / 1ps

module fpha_scan
    import fpha_pkg::*;
#(
    parameter int NUM_HOLES = NUM_HOLES_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF,
    localparam int IDX_W = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1,
    localparam int CNT_W = $clog2(NUM_HOLES + 1),
    localparam int CW    = (SIZE_BITS > AMOUNT_W) ? SIZE_BITS : AMOUNT_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  req_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output rsp_t                 out_data,
    input  logic [POLICY_W-1:0]  policy,
    input  logic [HOLES_W-1:0]   holes_in_use,
    output logic                 rd_en,
    output logic [IDX_W-1:0]     rd_addr,
    input  logic [SIZE_BITS-1:0] rd_data,
    output logic                 wr_en,
    output logic [IDX_W-1:0]     wr_addr,
    output logic [SIZE_BITS-1:0] wr_data
);

    scan_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     lim_reg, lim_next;
    logic [AMOUNT_W-1:0]  amt_reg, amt_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] rem_reg, rem_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_t                 out_data_reg, out_data_next;

    logic [7:0]           holes_w;
    logic [7:0]           lim_w;
    logic [7:0]           idx_w;
    logic                 idx_ok;
    logic [CW-1:0]        amount_w;
    logic [CW-1:0]        have_w;
    logic [CW-1:0]        need_w;
    logic [CW-1:0]        diff_w;
    logic [SIZE_BITS-1:0] diff;
    logic                 fits;
    logic                 take;
    logic                 last;
    logic [7:0]           pick_w;
    logic [CW-1:0]        rem_w;
    logic                 out_free;

    always_comb
    begin
        holes_w  = 8'(holes_in_use);
        lim_w    = (holes_w > 8'(NUM_HOLES)) ? 8'(NUM_HOLES) : holes_w;
        idx_w    = 8'(in_data.hole_index);
        idx_ok   = idx_w < 8'(NUM_HOLES);
        amount_w = CW'(in_data.amount);
        have_w   = CW'(rd_data);
        need_w   = CW'(amt_reg);
        fits     = have_w >= need_w;
        diff_w   = have_w - need_w;
        diff     = diff_w[SIZE_BITS-1:0];
        pick_w   = 8'(pick_reg);
        rem_w    = CW'(rem_reg);
        out_free = !out_valid_reg || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            lim_reg       <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            lim_reg       <= lim_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg      <= amt_next;
        pick_reg     <= pick_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        lim_next       = lim_reg;
        amt_next       = amt_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        in_stall       = 1'b1;
        rd_en          = 1'b0;
        rd_addr        = k_reg + IDX_W'(1);
        wr_en          = 1'b0;
        wr_addr        = pick_reg;
        wr_data        = rem_reg;
        take           = 1'b0;
        last           = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_data.cmd == CMD_LOAD)
                    begin
                        wr_en   = idx_ok;
                        wr_addr = idx_w[IDX_W-1:0];
                        wr_data = amount_w[SIZE_BITS-1:0];
                    end
                    else
                    begin
                        amt_next   = in_data.amount;
                        found_next = 1'b0;
                        pick_next  = '0;
                        rem_next   = '0;
                        k_next     = '0;
                        lim_next   = lim_w[CNT_W-1:0];
                        if (lim_w == 8'd0)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            // rd_data holds hole k_reg, read in the previous cycle
            ST_SCAN:
            begin
                case (policy_t'(policy))
                    POL_BEST:  take = fits && (!found_reg || diff < rem_reg);
                    POL_WORST: take = fits && (!found_reg || diff > rem_reg);
                    default:   take = fits;
                endcase
                if (take)
                begin
                    found_next = 1'b1;
                    pick_next  = k_reg;
                    rem_next   = diff;
                end
                last = (CNT_W'(k_reg) + CNT_W'(1) == lim_reg) ||
                       (fits && policy != POL_BEST && policy != POL_WORST);
                if (last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd_en  = 1'b1;
                    k_next = k_reg + IDX_W'(1);
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    wr_en                      = found_reg;
                    out_valid_next             = 1'b1;
                    out_data_next.granted      = found_reg;
                    out_data_next.chosen_hole  = found_reg ? pick_w[HIDX_W-1:0] : '0;
                    out_data_next.left_in_hole = found_reg ? rem_w[AMOUNT_W-1:0] : '0;
                    state_next                 = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/fit_policy_hole_allocator_core.sv =====
`timescale 1ns / 1ps

// Hole allocator: keeps NUM_HOLES free-hole sizes in a single-port-read,
// single-port-write RAM (registered read, unwritten holes read as
// zero). A load transaction writes one hole and returns nothing. A
// request transaction scans holes 0 .. min(holes_in_use, NUM_HOLES)-1,
// one RAM read per cycle, under first, best or worst fit (ties to the
// lowest index), then writes the shrunk hole back if one fits and posts
// one result; under first fit the scan stops at the first hole that fits.
// A posted result may wait on out_stall while the next transaction is
// accepted. Write policy and holes_in_use only while no request is in
// flight.
module fit_policy_hole_allocator_core
    import fpha_pkg::*;
#(
    parameter int NUM_HOLES = NUM_HOLES_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  req_t                  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output rsp_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (NUM_HOLES > 1) ? $clog2(NUM_HOLES) : 1;

    logic [POLICY_W-1:0]  policy_reg;
    logic [HOLES_W-1:0]   holes_reg;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [SIZE_BITS-1:0] rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            holes_reg  <= HOLES_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_POLICY: policy_reg <= cfg_data[POLICY_W-1:0];
                CFG_HOLES:  holes_reg  <= cfg_data[HOLES_W-1:0];
                default:    ;
            endcase
        end
    end

    fpha_mem #(
        .NUM_HOLES (NUM_HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    fpha_scan #(
        .NUM_HOLES (NUM_HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .policy       (policy_reg),
        .holes_in_use (holes_reg),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

endmodule

// ===== hdl/fpha_checker.sv =====
`timescale 1ns / 1ps

module fpha_checker
    import fpha_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input req_t in_data,
    input logic out_valid,
    input logic out_stall,
    input rsp_t out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // a refused request reports hole zero and no remainder
    a_deny_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.granted |->
            out_data.chosen_hole == '0 && out_data.left_in_hole == '0)
        else $error("denied result carries data");

    // after a load the input is not stalled in the next cycle
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.cmd == CMD_LOAD |=> !in_stall)
        else $error("input stalled after load");

    // a request keeps the input stalled while it scans
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.cmd == CMD_REQUEST |=> in_stall)
        else $error("input open during request");

endmodule

bind fit_policy_hole_allocator_core fpha_checker u_fpha_checker (.*);
